// ----- design/scld_pkg.sv -----
`timescale 1ns / 1ps

package scld_pkg;

  localparam int LINE_CAP = 96;
  localparam int LEN_W    = $clog2(LINE_CAP);
  localparam int NUM_KEYS = 6;
  localparam int KEY_CHARS = 6;

  typedef enum logic [2:0] {
    EV_HELP     = 3'd0,
    EV_SHOW     = 3'd1,
    EV_START    = 3'd2,
    EV_STOP     = 3'd3,
    EV_PAUSE    = 3'd4,
    EV_RESUME   = 3'd5,
    EV_UNKNOWN  = 3'd6,
    EV_OVERFLOW = 3'd7
  } event_t;

  typedef enum logic [2:0] {
    RS_UNKNOWN = 3'd0,
    RS_STARTED = 3'd1,
    RS_PAUSED  = 3'd2,
    RS_RESUMED = 3'd3,
    RS_STOPPED = 3'd4
  } run_state_t;

  // keyword text, first character in the top byte, zero padded
  localparam logic [8*KEY_CHARS-1:0] KEY_TEXT [NUM_KEYS] = '{
    {"HELP", 16'h0000},
    {"SHOW", 16'h0000},
    {"START", 8'h00},
    {"STOP", 16'h0000},
    {"PAUSE", 8'h00},
    "RESUME"
  };

  localparam logic [2:0] KEY_LEN [NUM_KEYS] = '{3'd4, 3'd4, 3'd5, 3'd4, 3'd5, 3'd6};

  // one decoded line or overflow, handed to the run-state machine
  typedef struct packed {
    logic   valid;
    event_t ev;
  } cmd_t;

  typedef struct packed {
    logic       accepted;
    run_state_t state_next;
  } resp_t;

  function automatic logic [7:0] key_char(input int k, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (pos < 3'(KEY_CHARS)) begin
      ch = KEY_TEXT[k][8*(KEY_CHARS-1-int'(pos)) +: 8];
    end
    return ch;
  endfunction

endpackage

// ----- design/scld_if.sv -----
`timescale 1ns / 1ps

interface scld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface scld_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic       accepted;
  logic [2:0] run_state_out;
  logic       report_enabled;

  modport source (output valid, output event_res, output accepted,
                  output run_state_out, output report_enabled, input ready);
  modport sink (input valid, input event_res, input accepted,
                input run_state_out, input report_enabled, output ready);
endinterface

// ----- design/scld_run_fsm.sv -----
`timescale 1ns / 1ps

module scld_run_fsm
  import scld_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cmd_t  cmd,
  output resp_t resp
);

  run_state_t run_state;

  always_comb begin
    logic running;
    running = (run_state == RS_STARTED) || (run_state == RS_PAUSED) ||
              (run_state == RS_RESUMED);
    resp.accepted   = 1'b0;
    resp.state_next = run_state;
    unique case (cmd.ev)
      EV_START: begin
        if (!running) begin
          resp.accepted   = 1'b1;
          resp.state_next = RS_STARTED;
        end
      end
      EV_STOP: begin
        resp.accepted   = 1'b1;
        resp.state_next = RS_STOPPED;
      end
      EV_PAUSE: begin
        if (run_state == RS_STARTED || run_state == RS_RESUMED) begin
          resp.accepted   = 1'b1;
          resp.state_next = RS_PAUSED;
        end
      end
      EV_RESUME: begin
        if (run_state == RS_PAUSED) begin
          resp.accepted   = 1'b1;
          resp.state_next = RS_RESUMED;
        end
      end
      default: begin
        resp.accepted   = 1'b0;
        resp.state_next = run_state;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_state <= RS_UNKNOWN;
    end else if (cmd.valid) begin
      run_state <= resp.state_next;
    end
  end

endmodule

// ----- design/serial_command_line_decoder.sv -----
`timescale 1ns / 1ps
// Results: a result passes the input register, then the result register, after its
//   terminating or overflowing byte is transferred; a stalled output holds both.
// Throughput: one byte per cycle unless the output stalls; one line-state pass per byte.
// Reset: synchronous, active high; clears run state to unknown, drops any partial
//   line and empties the input and result registers.

module serial_command_line_decoder
  import scld_pkg::*;
(
  input logic       clk,
  input logic       rst,
  scld_in_if.sink   in_ch,
  scld_out_if.source out_ch
);

  typedef enum logic [1:0] {
    TP_BEFORE = 2'd0,
    TP_IN     = 2'd1,
    TP_AFTER  = 2'd2
  } token_phase_t;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_adv;

  // line state
  logic [LEN_W-1:0]    line_length, line_length_next;
  logic                dropping, dropping_next;
  token_phase_t        token_phase, token_phase_next;
  logic [2:0]          token_length, token_length_next;
  logic [NUM_KEYS-1:0] keyword_match, keyword_match_next;
  logic                content_ended, content_ended_next;

  logic   emit;
  event_t emit_ev;
  cmd_t   cmd;
  resp_t  resp;

  // result register
  logic       out_valid;
  event_t     out_ev;
  logic       out_acc;
  run_state_t out_rs;

  assign s1_adv      = !out_valid || out_ch.ready;
  assign in_ch.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte <= in_ch.rx_byte;
    end
  end

  always_comb begin
    logic [7:0] c;
    logic [7:0] u;
    logic       is_term;
    logic       is_sep;
    event_t     hit;
    c       = s1_byte;
    u       = (c >= 8'd97 && c <= 8'd122) ? (c - 8'd32) : c;
    is_term = (c == 8'd13) || (c == 8'd10);
    is_sep  = (c == 8'd32) || (c == 8'd9) || (c == 8'd44);

    hit = EV_UNKNOWN;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (keyword_match[k] && token_length == KEY_LEN[k]) begin
        hit = event_t'(3'(k));
      end
    end

    line_length_next   = line_length;
    dropping_next      = dropping;
    token_phase_next   = token_phase;
    token_length_next  = token_length;
    keyword_match_next = keyword_match;
    content_ended_next = content_ended;
    emit               = 1'b0;
    emit_ev            = EV_UNKNOWN;

    priority if (is_term) begin
      if (dropping || line_length != '0) begin
        // terminator closes the line in every case that reaches here
        line_length_next   = '0;
        token_phase_next   = TP_BEFORE;
        token_length_next  = 3'd0;
        keyword_match_next = '1;
        content_ended_next = 1'b0;
        dropping_next      = 1'b0;
        if (!dropping && token_phase != TP_BEFORE) begin
          emit    = 1'b1;
          emit_ev = hit;
        end
      end
    end else if (dropping) begin
      // drop until the next terminator
    end else if (line_length >= LEN_W'(LINE_CAP - 1)) begin
      dropping_next      = 1'b1;
      line_length_next   = '0;
      token_phase_next   = TP_BEFORE;
      token_length_next  = 3'd0;
      keyword_match_next = '1;
      content_ended_next = 1'b0;
      emit               = 1'b1;
      emit_ev            = EV_OVERFLOW;
    end else begin
      line_length_next = line_length + LEN_W'(1);
      priority if (content_ended) begin
      end else if (c == 8'd0) begin
        content_ended_next = 1'b1;
        if (token_phase == TP_IN) token_phase_next = TP_AFTER;
      end else if (is_sep) begin
        if (token_phase == TP_IN) token_phase_next = TP_AFTER;
      end else if (token_phase != TP_AFTER) begin
        token_phase_next = TP_IN;
        for (int k = 0; k < NUM_KEYS; k++) begin
          if (token_length >= KEY_LEN[k] || key_char(k, token_length) != u) begin
            keyword_match_next[k] = 1'b0;
          end
        end
        if (token_length != 3'd7) token_length_next = token_length + 3'd1;
      end else begin
        // hold: bytes after the first token leave it unchanged
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length   <= '0;
      dropping      <= 1'b0;
      token_phase   <= TP_BEFORE;
      token_length  <= 3'd0;
      keyword_match <= '1;
      content_ended <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      line_length   <= line_length_next;
      dropping      <= dropping_next;
      token_phase   <= token_phase_next;
      token_length  <= token_length_next;
      keyword_match <= keyword_match_next;
      content_ended <= content_ended_next;
    end
  end

  assign cmd.valid = s1_valid && s1_adv && emit;
  assign cmd.ev    = emit_ev;

  scld_run_fsm u_run_fsm (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .resp (resp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ev  <= emit_ev;
      out_acc <= resp.accepted;
      out_rs  <= resp.state_next;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.event_res      = out_ev;
  assign out_ch.accepted       = out_acc;
  assign out_ch.run_state_out  = out_rs;
  assign out_ch.report_enabled = (out_rs == RS_STARTED) || (out_rs == RS_RESUMED);

  a_line_bound: assert property (@(posedge clk) disable iff (rst)
    line_length <= LEN_W'(LINE_CAP - 1))
    else $error("line length beyond capacity");

  a_acc_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_acc |->
      (out_ev == EV_START || out_ev == EV_STOP || out_ev == EV_PAUSE ||
       out_ev == EV_RESUME))
    else $error("accepted flag on a non run-control result");

  a_ovf_drop: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_adv && emit && emit_ev == EV_OVERFLOW |=> dropping)
    else $error("overflow without entering drop mode");

  a_drop_quiet: assert property (@(posedge clk) disable iff (rst)
    dropping |-> line_length == '0 && token_phase == TP_BEFORE)
    else $error("line state not cleared while dropping");

  a_stop_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ev == EV_STOP |-> out_acc && out_rs == RS_STOPPED)
    else $error("stop did not take effect");

endmodule

// ----- test/line_decoder_checker.sv -----
`timescale 1ns / 1ps

module line_decoder_checker
  import scld_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  scld_in_if         in_ch,
  scld_out_if        out_ch,
  output int         fail_count,
  output int         results_due
);

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_COMMA = 8'd44;

  typedef enum logic [1:0] {
    PH_BEFORE,
    PH_IN,
    PH_AFTER
  } token_phase_t;

  typedef struct packed {
    event_t     ev;
    logic       accepted;
    run_state_t run_state;
    logic       report_enabled;
  } line_result_t;

  localparam event_t KEY_EVENT [NUM_KEYS] = '{
    EV_HELP, EV_SHOW, EV_START, EV_STOP, EV_PAUSE, EV_RESUME
  };

  string keyword_text [NUM_KEYS] = '{"HELP", "SHOW", "START", "STOP", "PAUSE", "RESUME"};

  run_state_t    run_st;
  int            line_len;
  bit            dropping;
  token_phase_t  tok_phase;
  int            tok_len;
  logic [5:0]    key_hits;
  bit            content_done;
  line_result_t  pending_results[$];

  function automatic void clear_line();
    line_len     = 0;
    tok_phase    = PH_BEFORE;
    tok_len      = 0;
    key_hits     = '1;
    content_done = 1'b0;
  endfunction

  function automatic logic reports_on(input run_state_t s);
    return (s == RS_STARTED) || (s == RS_RESUMED);
  endfunction

  // Advance the line state by one byte; return 1 when the byte yields a result.
  function automatic bit predict_line_byte(input logic [7:0] c, output line_result_t res);
    int         hit;
    logic [7:0] up;
    bit         running;
    event_t     ev;
    res = '0;
    hit = NUM_KEYS;
    if (c == CH_CR || c == CH_LF) begin
      if (dropping) begin
        dropping = 1'b0;
        clear_line();
        return 1'b0;
      end
      if (line_len == 0) return 1'b0;
      if (tok_phase == PH_BEFORE) begin
        clear_line();
        return 1'b0;
      end
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (hit == NUM_KEYS && key_hits[k] && tok_len == keyword_text[k].len()) hit = k;
      end
      clear_line();
      running = (run_st == RS_STARTED) || (run_st == RS_PAUSED) || (run_st == RS_RESUMED);
      ev = (hit == NUM_KEYS) ? EV_UNKNOWN : KEY_EVENT[hit];
      case (ev)
        EV_START: begin
          if (!running) begin
            run_st       = RS_STARTED;
            res.accepted = 1'b1;
          end
        end
        EV_STOP: begin
          run_st       = RS_STOPPED;
          res.accepted = 1'b1;
        end
        EV_PAUSE: begin
          if (reports_on(run_st)) begin
            run_st       = RS_PAUSED;
            res.accepted = 1'b1;
          end
        end
        EV_RESUME: begin
          if (run_st == RS_PAUSED) begin
            run_st       = RS_RESUMED;
            res.accepted = 1'b1;
          end
        end
        default: ;
      endcase
      res.ev             = ev;
      res.run_state      = run_st;
      res.report_enabled = reports_on(run_st);
      return 1'b1;
    end

    if (dropping) return 1'b0;

    if (line_len >= LINE_CAP - 1) begin
      dropping = 1'b1;
      clear_line();
      res.ev             = EV_OVERFLOW;
      res.run_state      = run_st;
      res.report_enabled = reports_on(run_st);
      return 1'b1;
    end

    line_len++;
    if (content_done) return 1'b0;
    if (c == CH_NUL) begin
      content_done = 1'b1;
      if (tok_phase == PH_IN) tok_phase = PH_AFTER;
      return 1'b0;
    end
    if (c == CH_SPACE || c == CH_TAB || c == CH_COMMA) begin
      if (tok_phase == PH_IN) tok_phase = PH_AFTER;
      return 1'b0;
    end
    if (tok_phase == PH_BEFORE) tok_phase = PH_IN;
    if (tok_phase == PH_IN) begin
      up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (tok_len >= keyword_text[k].len() || keyword_text[k][tok_len] != up) key_hits[k] = 1'b0;
      end
      if (tok_len < 7) tok_len++;
    end
    return 1'b0;
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    line_result_t res;
    if (rst) begin
      run_st   = RS_UNKNOWN;
      dropping = 1'b0;
      clear_line();
      pending_results.delete();
      fail_count = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (predict_line_byte(in_ch.rx_byte, res)) pending_results.push_back(res);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected: event_res %0d", out_ch.event_res);
          fail_count++;
        end else begin
          res = pending_results.pop_front();
          compare_field("event_res", res.ev, out_ch.event_res);
          compare_field("accepted", res.accepted, out_ch.accepted);
          compare_field("run_state_out", res.run_state, out_ch.run_state_out);
          compare_field("report_enabled", res.report_enabled, out_ch.report_enabled);
        end
      end
    end
    results_due = pending_results.size();
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import scld_pkg::*;

  localparam int         STALL_LIMIT = 2000;
  localparam int         HOLD_CYCLES = 300;
  localparam int         BYTE_COUNT  = 1300;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_LF       = 8'd10;
  localparam logic [7:0] CH_NUL      = 8'd0;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int fail_count;
  int results_due;
  int bytes_sent  = 0;
  int idle_cycles = 0;
  bit fast_send   = 1'b0;
  bit fast_recv   = 1'b0;
  bit hold_request = 1'b0;

  string cmd_words [6] = '{"HELP", "SHOW", "START", "STOP", "PAUSE", "RESUME"};
  string sep_chars = " \t,";

  always #6 clk = ~clk;

  scld_in_if  in_ch();
  scld_out_if out_ch();

  serial_command_line_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  line_decoder_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = fast_send ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_cmd(input string s, input logic [7:0] term);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(term);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic [7:0] mixed_case(input logic [7:0] ch);
    if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1)) return ch + 8'd32;
    return ch;
  endfunction

  task automatic random_line();
    logic [7:0] bytes_q[$];
    logic [7:0] b;
    string      w;
    int         kind;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      // command word with random case, separators and arguments, at times a letter short or long
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
        bytes_q.push_back(sep_chars[$urandom_range(0, 2)]);
      w = cmd_words[$urandom_range(0, 5)];
      for (int i = 0; i < w.len(); i++) bytes_q.push_back(mixed_case(w[i]));
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1)) void'(bytes_q.pop_back());
        else bytes_q.push_back(mixed_case(8'($urandom_range("A", "Z"))));
      end
      if ($urandom_range(0, 3) == 0) begin
        bytes_q.push_back(sep_chars[$urandom_range(0, 2)]);
        repeat ($urandom_range(1, 5)) bytes_q.push_back(8'($urandom_range(33, 126)));
      end
    end else if (kind < 80) begin
      // empty, separator-only and zero-byte lines
      repeat ($urandom_range(0, 3)) bytes_q.push_back(sep_chars[$urandom_range(0, 2)]);
      if ($urandom_range(0, 1)) begin
        w = cmd_words[$urandom_range(0, 5)];
        for (int i = 0; i < w.len(); i++) begin
          if (i == $urandom_range(0, w.len())) bytes_q.push_back(CH_NUL);
          bytes_q.push_back(mixed_case(w[i]));
        end
      end
    end else if (kind < 97) begin
      repeat ($urandom_range(0, 12)) bytes_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      // long line around the capacity, overflowing most of the time
      repeat ($urandom_range(LINE_CAP - 3, LINE_CAP + 10)) begin
        b = 8'($urandom_range(0, 255));
        bytes_q.push_back((b == CH_CR || b == CH_LF) ? 8'h58 : b);
      end
    end
    bytes_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
    if (bytes_q[$] == CH_CR && $urandom_range(0, 5) == 0) bytes_q.push_back(CH_LF);
    foreach (bytes_q[i]) send_byte(bytes_q[i]);
  endtask

  // result sink: random stalls per transfer, one long hold-off on request
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      if (hold_request) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      stall = fast_recv ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int  line_no;
    bit  held;
    bit  drained;
    line_no = 0;
    held    = 1'b0;
    drained = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty lines, then run-state rules from unknown onward
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_cmd("pause", CH_LF);
    send_cmd("resume", CH_CR);
    send_cmd("stop", CH_LF);
    send_cmd("Start", CH_LF);
    send_cmd("START", CH_LF);
    send_cmd("pause", CH_LF);
    send_cmd("PAUSE", CH_LF);
    send_cmd("start", CH_LF);
    send_cmd("resume", CH_LF);
    send_cmd("Resume", CH_LF);
    send_cmd("pAuSe", CH_LF);
    send_cmd("resume", CH_CR);
    send_byte(CH_LF);
    send_cmd("stop", CH_LF);
    send_cmd(" \t,help, extra", CH_CR);
    send_cmd("show", CH_LF);
    // zero byte cuts the token short, or leaves no token at all
    send_cmd("sh", CH_NUL);
    send_cmd("ow", CH_LF);
    send_byte(CH_NUL);
    send_cmd("help", CH_LF);
    send_cmd(" , \t", CH_LF);
    send_cmd("helpx", CH_LF);
    send_cmd("STARTED", CH_LF);
    send_cmd("st", 8'hFF);
    send_byte(CH_LF);
    // exactly full line, then overflow with dropped bytes
    repeat (LINE_CAP - 1) send_byte("x");
    send_byte(CH_LF);
    repeat (LINE_CAP - 1) send_byte("a");
    send_cmd("bbstop", CH_LF);
    send_cmd("start", CH_CR);

    while (bytes_sent < BYTE_COUNT) begin
      if (line_no % 16 == 0) begin
        fast_send = ($urandom_range(0, 3) == 0);
        fast_recv = ($urandom_range(0, 3) == 0);
      end
      if (!held && bytes_sent >= 400) begin
        // back-pressure: sink holds off while commands keep arriving
        held         = 1'b1;
        hold_request = 1'b1;
        fast_send    = 1'b1;
        repeat (40) send_cmd("help", CH_LF);
      end
      if (!drained && bytes_sent >= 800) begin
        drained = 1'b1;
        release_input();
        wait (results_due == 0);
      end
      random_line();
      line_no++;
    end

    release_input();
    wait (results_due == 0);
    repeat (5) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
